/* rtl/lis_pkg.sv */
// Package with shared constants and payload types for the LIS core.
`timescale 1ns / 1ps
`default_nettype none
package lis_pkg;
  localparam int ITEM_MAX = 64;
  localparam int IDX_W    = 6;
  localparam int LEN_W    = 7;
  localparam int VAL_W    = 32;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last_item;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]        subseq_length;
    logic signed [VAL_W-1:0] element_value;
    logic [IDX_W-1:0]        element_position;
    logic                    final_result;
    logic                    overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        pos;
  } obuf_t;
endpackage
`default_nettype wire

/* rtl/lis_if.sv */
// Valid/ready channel interfaces for input and result transactions.
`timescale 1ns / 1ps
`default_nettype none
interface lis_in_if;
  logic               valid;
  logic               ready;
  lis_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lis_out_if;
  logic               valid;
  logic               ready;
  lis_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/lis_front.sv */
// Front end: accepts input transactions into a two-entry queue for the back end.
`timescale 1ns / 1ps
`default_nettype none
module lis_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  lis_in_if.sink                 in_ch,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output lis_pkg::in_item_t      q_item
);
  import lis_pkg::*;

  in_item_t    buf_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_item  = buf_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= in_ch.data;
  end
endmodule
`default_nettype wire

/* rtl/lis_back.sv */
// Back end: tail table search, predecessor links and subsequence readout.
`timescale 1ns / 1ps
`default_nettype none
module lis_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire lis_pkg::in_item_t q_item,
  lis_out_if.source              out_ch
);
  import lis_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SRCH   = 9'b000000010,
    S_CMP    = 9'b000000100,
    S_UPD    = 9'b000001000,
    S_FIN    = 9'b000010000,
    S_RTAIL  = 9'b000100000,
    S_WALK   = 9'b001000000,
    S_WSTORE = 9'b010000000,
    S_EMIT   = 9'b100000000
  } st_t;

  logic signed [VAL_W-1:0] tail_val [ITEM_MAX];
  logic [IDX_W-1:0]        tail_pos [ITEM_MAX];
  logic [LEN_W-1:0]        pred     [ITEM_MAX];
  logic signed [VAL_W-1:0] stored   [ITEM_MAX];
  obuf_t                   obuf     [ITEM_MAX];

  st_t                     st_r, st_nxt;
  logic [LEN_W-1:0]        lo_r, lo_nxt, hi_r, hi_nxt, len_r, len_nxt, cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        mid_r, mid_nxt, k_r, k_nxt, p_r, p_nxt;
  logic                    ovf_r, ovf_nxt, last_r, last_nxt, send_r, send_nxt;
  logic signed [VAL_W-1:0] v_r, v_nxt;
  logic                    ov_r, ov_nxt;
  out_item_t               od_r, od_nxt;

  logic signed [VAL_W-1:0] tv_rd, sv_rd;
  logic [IDX_W-1:0]        tp_rd;
  logic [LEN_W-1:0]        pd_rd;
  obuf_t                   ob_rd;

  logic [IDX_W-1:0]        ta, pa;
  logic [LEN_W:0]          sum;
  logic [LEN_W-1:0]        lo_m1, len_m1;
  logic                    sv_we, tl_we, ob_we;

  assign sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign lo_m1  = lo_r - 7'd1;
  assign len_m1 = len_r - 7'd1;
  assign ta     = (lo_r < hi_r) ? sum[IDX_W:1] : lo_r[IDX_W-1:0];
  assign pa     = (st_r == S_FIN) ? len_m1[IDX_W-1:0] : lo_m1[IDX_W-1:0];
  assign q_ready = (st_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;

  always_comb begin
    st_nxt   = st_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    mid_nxt  = mid_r;
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    last_nxt = last_r;
    v_nxt    = v_r;
    k_nxt    = k_r;
    p_nxt    = p_r;
    send_nxt = send_r;
    ov_nxt   = ov_r && !out_ch.ready;
    od_nxt   = od_r;
    sv_we    = 1'b0;
    tl_we    = 1'b0;
    ob_we    = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          v_nxt    = q_item.value;
          last_nxt = q_item.last_item;
          if (cnt_r < 7'(ITEM_MAX)) begin
            sv_we  = 1'b1;
            lo_nxt = '0;
            hi_nxt = len_r;
            st_nxt = S_SRCH;
          end else begin
            ovf_nxt = 1'b1;
            st_nxt  = S_FIN;
          end
        end
      end
      S_SRCH: begin
        mid_nxt = ta;
        st_nxt  = (lo_r < hi_r) ? S_CMP : S_UPD;
      end
      S_CMP: begin
        if (tv_rd < v_r) lo_nxt = {1'b0, mid_r} + 7'd1;
        else             hi_nxt = {1'b0, mid_r};
        st_nxt = S_SRCH;
      end
      S_UPD: begin
        if (!((lo_r < len_r) && (tv_rd == v_r))) begin
          tl_we = 1'b1;
          if (lo_r == len_r) len_nxt = len_r + 7'd1;
        end
        cnt_nxt = cnt_r + 7'd1;
        st_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!last_r) begin
          st_nxt = S_IDLE;
        end else if (len_r != '0) begin
          k_nxt  = len_m1[IDX_W-1:0];
          st_nxt = S_RTAIL;
        end else begin
          len_nxt = '0;
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
          st_nxt  = S_IDLE;
        end
      end
      S_RTAIL: begin
        p_nxt  = tp_rd;
        st_nxt = S_WALK;
      end
      S_WALK: begin
        st_nxt = S_WSTORE;
      end
      S_WSTORE: begin
        ob_we = 1'b1;
        p_nxt = pd_rd[IDX_W-1:0];
        if (k_r == '0) begin
          send_nxt = 1'b0;
          st_nxt   = S_EMIT;
        end else begin
          k_nxt  = k_r - 6'd1;
          st_nxt = S_WALK;
        end
      end
      S_EMIT: begin
        if (!send_r) begin
          send_nxt = 1'b1;
        end else if (!ov_r || out_ch.ready) begin
          ov_nxt                  = 1'b1;
          od_nxt.subseq_length    = len_r;
          od_nxt.element_value    = ob_rd.value;
          od_nxt.element_position = ob_rd.pos;
          od_nxt.final_result     = ({1'b0, k_r} == len_m1);
          od_nxt.overflow         = ovf_r;
          send_nxt                = 1'b0;
          if ({1'b0, k_r} == len_m1) begin
            len_nxt = '0;
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            st_nxt  = S_IDLE;
          end else begin
            k_nxt = k_r + 6'd1;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      len_r  <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      ov_r   <= 1'b0;
      send_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      ov_r   <= ov_nxt;
      send_r <= send_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    last_r <= last_nxt;
    v_r    <= v_nxt;
    k_r    <= k_nxt;
    p_r    <= p_nxt;
    od_r   <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (tl_we) tail_val[lo_r[IDX_W-1:0]] <= v_r;
    tv_rd <= tail_val[ta];
  end

  always_ff @(posedge clk) begin
    if (tl_we) tail_pos[lo_r[IDX_W-1:0]] <= cnt_r[IDX_W-1:0];
    tp_rd <= tail_pos[pa];
  end

  always_ff @(posedge clk) begin
    if (tl_we) pred[cnt_r[IDX_W-1:0]] <= (lo_r != '0) ? {1'b0, tp_rd} : 7'(ITEM_MAX);
    pd_rd <= pred[p_r];
  end

  always_ff @(posedge clk) begin
    if (sv_we) stored[cnt_r[IDX_W-1:0]] <= q_item.value;
    sv_rd <= stored[p_r];
  end

  always_ff @(posedge clk) begin
    if (ob_we) obuf[k_r] <= '{value: sv_rd, pos: p_r};
    ob_rd <= obuf[k_r];
  end
endmodule
`default_nettype wire

/* rtl/longest_increasing_subsequence_core.sv */
// Top level of the longest strictly increasing subsequence core.
//
// Input channel in_ch carries one signed 32-bit value per transaction and a
// last_item flag. A two-entry queue decouples intake from the search engine.
// Each accepted value runs a binary search over the tail memory, one
// registered read per probe, then updates the table. Up to 64 values are
// kept; later values are dropped and flag overflow on the readout.
// On the last item the engine walks predecessor links back (states S_WALK
// and S_WSTORE per element) into a readout buffer, then sends one result
// transaction per element in input order. While out_ch stalls, the output
// register holds and the engine waits; no new value is taken until the
// readout ends. After the final result, the length, item count and
// overflow flag clear for the next sequence. Synchronous active-low reset
// returns the engine to idle with an empty table; memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module longest_increasing_subsequence_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lis_in_if.sink     in_ch,
  lis_out_if.source  out_ch
);
  import lis_pkg::*;

  logic     q_valid, q_ready;
  in_item_t q_item;

  lis_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  lis_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .out_ch  (out_ch)
  );
endmodule
`default_nettype wire

/* rtl/lis_checker.sv */
// Port-level checker for the LIS core and its bind.
`timescale 1ns / 1ps
`default_nettype none
module lis_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire lis_pkg::out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.subseq_length != 7'd0) && (out_data.subseq_length <= 7'd64))
    else $error("subsequence length out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_len_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.final_result ##1 out_valid
      |-> out_data.subseq_length == $past(out_data.subseq_length))
    else $error("length changed within one readout");
endmodule

bind longest_increasing_subsequence_core lis_checker u_lis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
`default_nettype wire

/* dv/lis_tb_if.sv */
// Testbench copy note: channel interfaces come from the RTL; this file holds the run phase codes.
`timescale 1ns / 1ps
package lis_tb_pkg;
  typedef enum int {PH_SEND_IDLE, PH_RECV_IDLE, PH_NO_IDLE} idle_phase_t;
endpackage

/* dv/lis_checker.sv */
// Checker that predicts LIS readouts from input transactions and compares results.
`timescale 1ns / 1ps
module lis_tb_checker
  import lis_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lis_in_if.sink    in_mon,
  lis_out_if.sink   out_mon,
  output int        fail_count,
  output int        pending
);
  logic signed [VAL_W-1:0] tails [ITEM_MAX];
  logic [IDX_W-1:0]        tail_pos [ITEM_MAX];
  logic [LEN_W-1:0]        links [ITEM_MAX];
  logic signed [VAL_W-1:0] seen_vals [ITEM_MAX];
  int                      run_len;
  int                      n_seen;
  bit                      dropped;
  out_item_t               lis_expected [$];

  assign pending = lis_expected.size();

  task automatic report_mismatch(input string what, input out_item_t got,
                                 input out_item_t want);
    fail_count++;
    $display("MISMATCH %s: got %p want %p", what, got, want);
  endtask

  task automatic predict_lis(input in_item_t it);
    int lo, hi, mid, p;
    out_item_t r [$];
    out_item_t e;
    if (n_seen < ITEM_MAX) begin
      seen_vals[n_seen] = it.value;
      lo = 0;
      hi = run_len;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (tails[mid] < it.value) lo = mid + 1;
        else hi = mid;
      end
      if (!(lo < run_len && tails[lo] == it.value)) begin
        tails[lo] = it.value;
        tail_pos[lo] = n_seen;
        links[n_seen] = (lo > 0) ? tail_pos[lo-1] : ITEM_MAX;
        if (lo == run_len) run_len++;
      end
      n_seen++;
    end else begin
      dropped = 1;
    end
    if (it.last_item) begin
      if (run_len > 0) begin
        p = tail_pos[run_len-1];
        for (int k = run_len - 1; k >= 0; k--) begin
          e.subseq_length = run_len;
          e.element_value = seen_vals[p];
          e.element_position = p;
          e.final_result = (k == run_len - 1);
          e.overflow = dropped;
          r.push_front(e);
          p = links[p];
        end
      end
      lis_expected = {lis_expected, r};
      run_len = 0;
      n_seen = 0;
      dropped = 0;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      run_len <= 0;
      n_seen <= 0;
      dropped <= 0;
      fail_count <= 0;
      lis_expected.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) predict_lis(in_mon.data);
      if (out_mon.valid && out_mon.ready) begin
        if (lis_expected.size() == 0) begin
          report_mismatch("unexpected result", out_mon.data, '0);
        end else begin
          want = lis_expected.pop_front();
          if (out_mon.data.subseq_length !== want.subseq_length)
            report_mismatch("subseq_length", out_mon.data, want);
          if (out_mon.data.element_value !== want.element_value)
            report_mismatch("element_value", out_mon.data, want);
          if (out_mon.data.element_position !== want.element_position)
            report_mismatch("element_position", out_mon.data, want);
          if (out_mon.data.final_result !== want.final_result)
            report_mismatch("final_result", out_mon.data, want);
          if (out_mon.data.overflow !== want.overflow)
            report_mismatch("overflow", out_mon.data, want);
        end
      end
    end
  end
endmodule

/* dv/tb_top.sv */
// Testbench top: drives LIS sequences with idling and stalls, gives the verdict.
`timescale 1ns / 1ps
module tb_top;
  import lis_pkg::*;
  import lis_tb_pkg::*;

  localparam int WATCHDOG = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  int          fail_count;
  int          pending;
  int          idle_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off = 0;
  idle_phase_t phase;

  lis_in_if  in_ch ();
  lis_out_if out_ch ();

  longest_increasing_subsequence_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  lis_tb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch.sink),
    .out_mon    (out_ch.sink),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  always @(negedge clk) begin
    if (!rst_n || hold_off) out_ch.ready <= 0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG) begin
      $display("longest_increasing_subsequence_core test failed");
      $finish;
    end
  end

  task automatic send_item(input logic signed [VAL_W-1:0] v, input logic last);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_ch.valid = 1;
    in_ch.data = '{value: v, last_item: last};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value(int span);
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7fffffff - $urandom_range(2);
      2: return 32'sh80000000 + $urandom_range(2);
      default: return $signed($urandom_range(2 * span)) - span;
    endcase
  endfunction

  task automatic send_seq(input int n);
    int span;
    span = $urandom_range(1, 100);
    for (int i = 0; i < n; i++) send_item(pick_value(span), i == n - 1);
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    int sent;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    send_item(5, 1);
    send_item(32'sh80000000, 0);
    send_item(32'sh7fffffff, 1);
    send_item(3, 0);
    send_item(3, 0);
    send_item(3, 1);
    send_item(32'sh7fffffff, 0);
    send_item(0, 0);
    send_item(-1, 0);
    send_item(32'sh80000000, 1);
    send_item(-5, 0);
    send_item(32'sh55555555, 0);
    send_item(32'shaaaaaaaa, 0);
    send_item(1, 1);
    drain();
    for (int i = 0; i < 64; i++) send_item(i - 32, 0);
    send_item(100, 0);
    send_item(-100, 1);
    for (int i = 0; i < 64; i++) send_item($urandom, 0);
    send_item(7, 1);
    drain();

    hold_off = 1;
    for (int i = 0; i < 12; i++) send_item(i * 3 - 7, i == 11);
    fork
      begin repeat (300) @(negedge clk); hold_off = 0; end
      send_seq(8);
    join
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      phase = idle_phase_t'(ph);
      send_idle_pct = (phase == PH_SEND_IDLE) ? 26 : (phase == PH_RECV_IDLE) ? 63 : 0;
      recv_idle_pct = (phase == PH_SEND_IDLE) ? 63 : (phase == PH_RECV_IDLE) ? 26 : 0;
      sent = 0;
      while (sent < 75) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
        send_seq(n);
        sent += n;
      end
      drain();
    end

    if (fail_count == 0)
      $display("longest_increasing_subsequence_core test passed");
    else
      $display("longest_increasing_subsequence_core test failed");
    $finish;
  end
endmodule

/* sim.f */
rtl/lis_pkg.sv
rtl/lis_if.sv
rtl/lis_front.sv
rtl/lis_back.sv
rtl/longest_increasing_subsequence_core.sv
rtl/lis_checker.sv
dv/lis_tb_if.sv
dv/lis_checker.sv
dv/tb_top.sv
